### rtl/core/nnis_pkg.sv
package nnis_pkg;

	// Field and register widths
	localparam int COORD_W     = 10;
	localparam int PIXEL_W     = 8;
	localparam int SRC_SIZE_W  = 9;
	localparam int DST_SIZE_W  = 11;
	localparam int IN_TDATA_W  = 32;

	// Size limits and reset values of the size registers
	localparam int SRC_SIZE_CAP   = 256;
	localparam int DST_SIZE_CAP   = 1024;
	localparam int DST_SIZE_RESET = 256;

	// Result words in flight, from input handshake to output handshake
	localparam int OUT_FIFO_DEPTH = 8;

	typedef enum logic [1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_TARGET_WIDTH  = 2'd2,
		REG_TARGET_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_READ  = 1'b1
	} func_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	typedef struct packed {
		logic               coord_ok;
		logic [PIXEL_W-1:0] pixel;
	} result_t;

endpackage

### rtl/core/nearest_neighbor_image_scaler_core.sv
// Nearest-neighbor scaler over a source image held in one single-port memory.
// Throughput: one word per cycle while s_tready is high, pixel writes and scaled reads mixed freely.
// A read word passes stages s1, s2, s3, the registered memory read and the output FIFO before m_tvalid.
// After arst_n and after each size register write, s_tready stays low
// while the bit-serial divider forms both step ratios.
// Image memory contents are undefined after reset until written.
module nearest_neighbor_image_scaler_core #(
	parameter int MAX_SRC_WIDTH  = 256,
	parameter int MAX_SRC_HEIGHT = 256,
	parameter int FRAC_BITS      = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [nnis_pkg::DST_SIZE_W-1:0] cfg_data,
	// Input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata: coord_x [9:0], coord_y [19:10], pixel_in [27:20], zero [31:28]
	input  logic [nnis_pkg::IN_TDATA_W-1:0] s_tdata,
	// s_tuser: func [0]
	input  logic [0:0]                      s_tuser,
	// Output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: pixel_out [7:0]
	output logic [nnis_pkg::PIXEL_W-1:0]    m_tdata,
	// m_tuser: coord_ok [0]
	output logic [0:0]                      m_tuser
);
	import nnis_pkg::*;

	localparam int SRC_LIM_W = (MAX_SRC_WIDTH < SRC_SIZE_CAP) ? MAX_SRC_WIDTH : SRC_SIZE_CAP;
	localparam int SRC_LIM_H = (MAX_SRC_HEIGHT < SRC_SIZE_CAP) ? MAX_SRC_HEIGHT : SRC_SIZE_CAP;
	localparam int XW        = $clog2(SRC_LIM_W);
	localparam int YW        = $clog2(SRC_LIM_H);
	localparam int MEM_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int STEP_W    = SRC_SIZE_W + FRAC_BITS;
	localparam int PROD_W    = COORD_W + STEP_W;
	localparam int SHIFT_W   = PROD_W - FRAC_BITS;
	localparam int PEND_W    = $clog2(OUT_FIFO_DEPTH + 1);

	localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(MAX_SRC_WIDTH);

	// Clip a source size to 1..hi
	function automatic logic [SRC_SIZE_W-1:0] limit_src(
		input logic [SRC_SIZE_W-1:0] v,
		input logic [SRC_SIZE_W-1:0] hi
	);
		logic [SRC_SIZE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SRC_SIZE_W'(1);
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	// Clip a target size to 1..1024
	function automatic logic [DST_SIZE_W-1:0] limit_dst(input logic [DST_SIZE_W-1:0] v);
		logic [DST_SIZE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DST_SIZE_W'(1);
		end else if (v > DST_SIZE_W'(DST_SIZE_CAP)) begin
			r = DST_SIZE_W'(DST_SIZE_CAP);
		end
		return r;
	endfunction

	logic [SRC_SIZE_W-1:0] src_w_q;
	logic [SRC_SIZE_W-1:0] src_h_q;
	logic [DST_SIZE_W-1:0] dst_w_q;
	logic [DST_SIZE_W-1:0] dst_h_q;
	logic                  start_q;

	logic [STEP_W-1:0]     quot_x;
	logic [STEP_W-1:0]     quot_y;
	div_status_t           div_x;
	div_status_t           div_y;
	logic [STEP_W-1:0]     step_x_q;
	logic [STEP_W-1:0]     step_y_q;
	logic                  cfg_busy;

	logic                  in_acc;
	logic                  in_read;
	logic [COORD_W-1:0]    in_x;
	logic [COORD_W-1:0]    in_y;
	logic                  in_ok;

	logic                  vld_s1;
	logic                  rd_s1;
	logic                  ok_s1;
	logic [COORD_W-1:0]    x_s1;
	logic [COORD_W-1:0]    y_s1;
	logic [PIXEL_W-1:0]    pix_s1;

	logic                  vld_s2;
	logic                  rd_s2;
	logic                  ok_s2;
	logic [COORD_W-1:0]    x_s2;
	logic [COORD_W-1:0]    y_s2;
	logic [PIXEL_W-1:0]    pix_s2;
	logic [PROD_W-1:0]     prodx_s2;
	logic [PROD_W-1:0]     prody_s2;

	logic [SRC_SIZE_W-1:0] last_x;
	logic [SRC_SIZE_W-1:0] last_y;
	logic [SHIFT_W-1:0]    shx;
	logic [SHIFT_W-1:0]    shy;
	logic [SHIFT_W-1:0]    map_x;
	logic [SHIFT_W-1:0]    map_y;
	logic [XW-1:0]         sx;
	logic [YW-1:0]         sy;
	logic [ADDR_W-1:0]     addr;

	logic                  we_s3;
	logic                  re_s3;
	logic                  ok_s3;
	logic [ADDR_W-1:0]     addr_s3;
	logic [PIXEL_W-1:0]    pix_s3;

	logic                  vld_s4;
	logic                  ok_s4;
	logic [PIXEL_W-1:0]    rdata;
	result_t               push_word;
	result_t               head;

	logic [PEND_W-1:0]     pend_q;
	logic                  out_acc;

	// Hold clipped sizes; any size write restarts the step division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SRC_SIZE_W'(SRC_LIM_W);
			src_h_q <= SRC_SIZE_W'(SRC_LIM_H);
			dst_w_q <= DST_SIZE_W'(DST_SIZE_RESET);
			dst_h_q <= DST_SIZE_W'(DST_SIZE_RESET);
			start_q <= 1'b1;
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				start_q <= 1'b1;
				case (cfg_reg_t'(cfg_index))
					REG_SOURCE_WIDTH: begin
						src_w_q <= limit_src(cfg_data[SRC_SIZE_W-1:0], SRC_SIZE_W'(SRC_LIM_W));
					end
					REG_SOURCE_HEIGHT: begin
						src_h_q <= limit_src(cfg_data[SRC_SIZE_W-1:0], SRC_SIZE_W'(SRC_LIM_H));
					end
					REG_TARGET_WIDTH: begin
						dst_w_q <= limit_dst(cfg_data);
					end
					REG_TARGET_HEIGHT: begin
						dst_h_q <= limit_dst(cfg_data);
					end
					default: begin
						start_q <= 1'b0;
					end
				endcase
			end
		end
	end

	nnis_step_div #(
		.DVD_W (STEP_W),
		.DVS_W (DST_SIZE_W)
	) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend ({src_w_q, {FRAC_BITS{1'b0}}}),
		.divisor  (dst_w_q),
		.quotient (quot_x),
		.status   (div_x)
	);

	nnis_step_div #(
		.DVD_W (STEP_W),
		.DVS_W (DST_SIZE_W)
	) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend ({src_h_q, {FRAC_BITS{1'b0}}}),
		.divisor  (dst_h_q),
		.quotient (quot_y),
		.status   (div_y)
	);

	// Load the steps as quotient plus one when division completes
	always_ff @(posedge clk) begin
		if (div_x.done) begin
			step_x_q <= quot_x + STEP_W'(1);
		end
		if (div_y.done) begin
			step_y_q <= quot_y + STEP_W'(1);
		end
	end

	assign cfg_busy = start_q | div_x.busy | div_y.busy | div_x.done | div_y.done;

	// Accept while steps are settled and a result slot is reserved
	assign s_tready = !cfg_busy && (pend_q < PEND_W'(OUT_FIFO_DEPTH));
	assign in_acc   = s_tvalid && s_tready;
	assign in_read  = (func_t'(s_tuser[0]) == FUNC_READ);
	assign in_x     = s_tdata[COORD_W-1:0];
	assign in_y     = s_tdata[2*COORD_W-1:COORD_W];

	// Bounds check: target size for reads, source size for writes
	always_comb begin
		if (in_read) begin
			in_ok = ({1'b0, in_x} < dst_w_q) && ({1'b0, in_y} < dst_h_q);
		end else begin
			in_ok = (in_x < COORD_W'(src_w_q)) && (in_y < COORD_W'(src_h_q));
		end
	end

	// Stage control: valid and kind of each word in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			we_s3  <= 1'b0;
			re_s3  <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_acc;
			vld_s2 <= vld_s1;
			we_s3  <= vld_s2 && !rd_s2 && ok_s2;
			re_s3  <= vld_s2 && rd_s2;
			vld_s4 <= re_s3;
		end
	end

	// Stage payload: capture, multiply by step, then form the address
	always_ff @(posedge clk) begin
		rd_s1    <= in_read;
		ok_s1    <= in_ok;
		x_s1     <= in_x;
		y_s1     <= in_y;
		pix_s1   <= s_tdata[2*COORD_W+PIXEL_W-1:2*COORD_W];

		rd_s2    <= rd_s1;
		ok_s2    <= ok_s1;
		x_s2     <= x_s1;
		y_s2     <= y_s1;
		pix_s2   <= pix_s1;
		prodx_s2 <= PROD_W'(x_s1) * PROD_W'(step_x_q);
		prody_s2 <= PROD_W'(y_s1) * PROD_W'(step_y_q);

		ok_s3    <= ok_s2;
		addr_s3  <= addr;
		pix_s3   <= pix_s2;

		ok_s4    <= ok_s3;
	end

	// Drop the fraction and clamp to the last source column and row
	always_comb begin
		last_x = src_w_q - SRC_SIZE_W'(1);
		last_y = src_h_q - SRC_SIZE_W'(1);
		shx    = prodx_s2[PROD_W-1:FRAC_BITS];
		shy    = prody_s2[PROD_W-1:FRAC_BITS];
		map_x  = (shx > SHIFT_W'(last_x)) ? SHIFT_W'(last_x) : shx;
		map_y  = (shy > SHIFT_W'(last_y)) ? SHIFT_W'(last_y) : shy;
		sx     = rd_s2 ? map_x[XW-1:0] : x_s2[XW-1:0];
		sy     = rd_s2 ? map_y[YW-1:0] : y_s2[YW-1:0];
		addr   = ADDR_W'(sy) * ROW_PITCH + ADDR_W'(sx);
	end

	nnis_pixel_mem #(
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (we_s3),
		.addr  (addr_s3),
		.wdata (pix_s3),
		.rdata (rdata)
	);

	// Zero the pixel of an out-of-bounds read
	assign push_word.coord_ok = ok_s4;
	assign push_word.pixel    = ok_s4 ? rdata : '0;

	nnis_out_fifo #(
		.DEPTH (OUT_FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s4),
		.push_word (push_word),
		.pop       (m_tready),
		.valid     (m_tvalid),
		.head      (head)
	);

	assign out_acc = m_tvalid && m_tready;

	// Count read words between acceptance and delivery
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({in_acc && in_read, out_acc})
				2'b10:   pend_q <= pend_q + PEND_W'(1);
				2'b01:   pend_q <= pend_q - PEND_W'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	assign m_tdata    = head.pixel;
	assign m_tuser[0] = head.coord_ok;

endmodule

### rtl/core/nnis_step_div.sv
module nnis_step_div #(
	parameter int DVD_W = 25,
	parameter int DVS_W = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DVD_W-1:0]      dividend,
	input  logic [DVS_W-1:0]      divisor,
	output logic [DVD_W-1:0]      quotient,
	output nnis_pkg::div_status_t status
);
	import nnis_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   rem_sh;
	logic             fits;
	logic [DVS_W-1:0] rem_next;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh   = {rem_q, dvd_q[DVD_W-1]};
		fits     = (rem_sh >= {1'b0, divisor});
		rem_next = fits ? DVS_W'(rem_sh - {1'b0, divisor}) : rem_sh[DVS_W-1:0];
	end

	// Sequence the steps, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend register turns into the quotient as bits shift through
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign quotient    = dvd_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

### rtl/core/nnis_pixel_mem.sv
module nnis_pixel_mem #(
	parameter int DEPTH  = 65536,
	parameter int ADDR_W = 16
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [ADDR_W-1:0]            addr,
	input  logic [nnis_pkg::PIXEL_W-1:0] wdata,
	output logic [nnis_pkg::PIXEL_W-1:0] rdata
);
	import nnis_pkg::*;

	logic [PIXEL_W-1:0] mem [DEPTH];
	logic [PIXEL_W-1:0] rdata_q;

	// Single port: write or read the addressed pixel, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/nnis_out_fifo.sv
module nnis_out_fifo #(
	parameter int DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  nnis_pkg::result_t push_word,
	input  logic              pop,
	output logic              valid,
	output nnis_pkg::result_t head
);
	import nnis_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	result_t        slot_q [DEPTH];
	logic [PTR_W:0] wr_ptr_q;
	logic [PTR_W:0] rd_ptr_q;

	// Advance pointers; the extra bit tells full from empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + (PTR_W + 1)'(1);
			end
			if (pop && valid) begin
				rd_ptr_q <= rd_ptr_q + (PTR_W + 1)'(1);
			end
		end
	end

	// Store the result word
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q[PTR_W-1:0]] <= push_word;
		end
	end

	assign valid = (wr_ptr_q != rd_ptr_q);
	assign head  = slot_q[rd_ptr_q[PTR_W-1:0]];

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
	import nnis_pkg::*;

	localparam int FRAC          = 16;
	localparam int ROW_PITCH     = 256;
	localparam int STEP_CALC_CYC = 9 + FRAC + 2;
	localparam int SETTLE_CYC    = 8;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_WORDS   = 178;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		func_t              op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [PIXEL_W-1:0] pix;
	} pixel_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [1:0]            cfg_index = '0;
	logic [DST_SIZE_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [PIXEL_W-1:0]    m_tdata;
	logic [0:0]            m_tuser;

	// Words waiting to go out and results still owed by the block
	pixel_word_t pending_words[$];
	result_t     expected_pixels[$];
	pixel_word_t held_word;
	result_t     want;

	// Shadow of the scaler: register copies, effective sizes, steps and image
	int unsigned       src_w_reg = 256, src_h_reg = 256, dst_w_reg = 256, dst_h_reg = 256;
	int unsigned       src_w_eff = 256, src_h_eff = 256, dst_w_eff = 256, dst_h_eff = 256;
	longint unsigned   step_x = 65537, step_y = 65537;
	logic [PIXEL_W-1:0] src_image [0:ROW_PITCH*ROW_PITCH-1];
	// Pixels that some queued word will have written by the time a read reaches them
	bit                filled_map [0:ROW_PITCH*ROW_PITCH-1];

	idle_mode_t idle_mode = IDLE_NONE;
	int unsigned words_queued = 0;
	int unsigned words_taken = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;

	nearest_neighbor_image_scaler_core #(
		.MAX_SRC_WIDTH (ROW_PITCH),
		.MAX_SRC_HEIGHT(ROW_PITCH),
		.FRAC_BITS     (FRAC)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned clamp_size(int unsigned v, int unsigned cap);
		if (v == 0)
			return 1;
		return (v > cap) ? cap : v;
	endfunction

	// Destination coordinate to source coordinate on one axis, held to the last column or row
	function automatic int unsigned map_coord(int unsigned d, longint unsigned step,
			int unsigned size);
		longint unsigned s;
		s = d;
		s = (s * step) >> FRAC;
		if (s > size - 1)
			s = size - 1;
		return int'(s);
	endfunction

	function automatic bit idle_roll(bit receiver_side);
		case (idle_mode)
			IDLE_SENDER:   return !receiver_side && ($urandom_range(99) < 51);
			IDLE_RECEIVER: return receiver_side && ($urandom_range(99) < 51);
			IDLE_BOTH:     return $urandom_range(99) < 18;
			default:       return 1'b0;
		endcase
	endfunction

	// Store a write, or work out the pixel a read must return
	function automatic void apply_word(pixel_word_t w);
		result_t r;
		int unsigned sx, sy;
		if (w.op == FUNC_WRITE) begin
			if (w.x < src_w_eff && w.y < src_h_eff)
				src_image[w.y * ROW_PITCH + w.x] = w.pix;
			return;
		end
		if (w.x >= dst_w_eff || w.y >= dst_h_eff) begin
			r.coord_ok = 1'b0;
			r.pixel = '0;
		end else begin
			sx = map_coord(w.x, step_x, src_w_eff);
			sy = map_coord(w.y, step_y, src_h_eff);
			r.coord_ok = 1'b1;
			r.pixel = src_image[sy * ROW_PITCH + sx];
		end
		expected_pixels.push_back(r);
	endfunction

	// Drive the input stream; score each word on the edge that takes it
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_word(held_word);
				words_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() > 0 && !idle_roll(1'b0)) begin
					held_word = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0000, held_word.pix, held_word.y, held_word.x};
					s_tuser <= held_word.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Check each result word against the oldest expectation
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected result word: pixel_out %0d coord_ok %0d",
						m_tdata, m_tuser[0]);
					mismatch_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (m_tdata !== want.pixel) begin
						$error("pixel_out: expected %0d, got %0d", want.pixel, m_tdata);
						mismatch_count++;
					end
					if (m_tuser[0] !== want.coord_ok) begin
						$error("coord_ok: expected %0d, got %0d", want.coord_ok, m_tuser[0]);
						mismatch_count++;
					end
				end
			end
			m_tready <= !idle_roll(1'b1);
		end
	end

	// End the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[DST_SIZE_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SOURCE_WIDTH:  src_w_reg = val & 'h1FF;
			REG_SOURCE_HEIGHT: src_h_reg = val & 'h1FF;
			REG_TARGET_WIDTH:  dst_w_reg = val & 'h7FF;
			REG_TARGET_HEIGHT: dst_h_reg = val & 'h7FF;
		endcase
		src_w_eff = clamp_size(src_w_reg, SRC_SIZE_CAP);
		src_h_eff = clamp_size(src_h_reg, SRC_SIZE_CAP);
		dst_w_eff = clamp_size(dst_w_reg, DST_SIZE_CAP);
		dst_h_eff = clamp_size(dst_h_reg, DST_SIZE_CAP);
		step_x = ((longint'(src_w_eff) << FRAC) / dst_w_eff) + 1;
		step_y = ((longint'(src_h_eff) << FRAC) / dst_h_eff) + 1;
		// the divider holds off input while it forms the new steps
		repeat (STEP_CALC_CYC + 4) @(posedge clk);
	endtask

	// Wait until every queued word is taken and every result is back
	task automatic drain();
		do
			@(posedge clk);
		while (words_taken != words_queued || expected_pixels.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic push_write(int unsigned x, int unsigned y, int unsigned pix);
		pixel_word_t w;
		w.op = FUNC_WRITE;
		w.x = x[COORD_W-1:0];
		w.y = y[COORD_W-1:0];
		w.pix = pix[PIXEL_W-1:0];
		pending_words.push_back(w);
		words_queued++;
		if (x < src_w_eff && y < src_h_eff)
			filled_map[y * ROW_PITCH + x] = 1'b1;
	endtask

	// Queue a read, preceded by a write when the pixel it lands on was never stored
	task automatic push_read(int unsigned x, int unsigned y);
		pixel_word_t w;
		int unsigned sx, sy;
		if (x < dst_w_eff && y < dst_h_eff) begin
			sx = map_coord(x, step_x, src_w_eff);
			sy = map_coord(y, step_y, src_h_eff);
			if (!filled_map[sy * ROW_PITCH + sx])
				push_write(sx, sy, $urandom_range(255));
		end
		w.op = FUNC_READ;
		w.x = x[COORD_W-1:0];
		w.y = y[COORD_W-1:0];
		w.pix = $urandom_range(255);
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic random_word();
		int unsigned r;
		int unsigned x, y;
		r = $urandom_range(99);
		if (r < 15) begin
			if ($urandom_range(1)) begin
				x = $urandom_range(src_w_eff - 1);
				y = $urandom_range(src_h_eff - 1);
			end else begin
				x = $urandom_range(1023);
				y = $urandom_range(1023);
			end
			push_write(x, y, $urandom_range(255));
		end else if (r < 27) begin
			push_read($urandom_range(1023), $urandom_range(1023));
		end else begin
			// lean on the far edges, where mapping may run past the source
			x = ($urandom_range(4) == 0) ? dst_w_eff - 1 : $urandom_range(dst_w_eff - 1);
			y = ($urandom_range(4) == 0) ? dst_h_eff - 1 : $urandom_range(dst_h_eff - 1);
			push_read(x, y);
		end
	endtask

	// Reconfigure while idle, then run random traffic with one full pause midway
	task automatic run_phase(int unsigned sw, int unsigned sh, int unsigned tw,
			int unsigned th, idle_mode_t mode);
		int unsigned half_mark, end_mark;
		drain();
		write_reg(REG_SOURCE_WIDTH, sw);
		write_reg(REG_SOURCE_HEIGHT, sh);
		write_reg(REG_TARGET_WIDTH, tw);
		write_reg(REG_TARGET_HEIGHT, th);
		idle_mode = mode;
		half_mark = words_queued + PHASE_WORDS / 2;
		end_mark = words_queued + PHASE_WORDS;
		while (words_queued < half_mark)
			random_word();
		drain();
		while (words_queued < end_mark)
			random_word();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Corners, ignored writes, out-of-bounds reads and an overwrite at reset sizes
		push_write(0, 0, 'h00);
		push_write(255, 255, 'hFF);
		push_write(255, 0, 'hA5);
		push_write(0, 255, 'h5A);
		push_write(256, 3, 'h11);
		push_write(1023, 1023, 'hEE);
		push_write(3, 300, 'h77);
		push_read(0, 0);
		push_read(255, 255);
		push_read(255, 0);
		push_read(0, 255);
		push_read(256, 0);
		push_read(0, 256);
		push_read(1023, 1023);
		push_read(0, 1023);
		push_read(128, 77);
		push_write(0, 0, 'h3C);
		push_read(0, 0);
		push_read(1023, 0);

		// Sizes at and beyond their limits, then ordinary and random ones
		run_phase(0, 1, 2047, 1024, IDLE_NONE);
		run_phase(511, 300, 0, 1, IDLE_SENDER);
		run_phase(16, 16, 40, 40, IDLE_RECEIVER);
		run_phase(200, 100, 50, 1000, IDLE_BOTH);
		run_phase(256, 256, 1024, 1024, IDLE_NONE);
		run_phase(7, 13, 1023, 5, IDLE_SENDER);
		run_phase($urandom_range(1, 256), $urandom_range(1, 256),
			$urandom_range(1, 1024), $urandom_range(1, 1024), IDLE_RECEIVER);
		run_phase($urandom_range(1, 256), $urandom_range(1, 256),
			$urandom_range(1, 1024), $urandom_range(1, 1024), IDLE_BOTH);

		drain();
		if (mismatch_count == 0 && expected_pixels.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
